// File: rtl/tbpdc_pkg.sv
`timescale 1ns / 1ps

package tbpdc_pkg;

    localparam int TIME_BITS_DEF = 14;
    localparam int THR_W         = 14;
    localparam int CFG_IDX_W     = 4;
    localparam int MAX_EV        = 4;
    localparam int EV_IDX_W      = $clog2(MAX_EV);
    localparam int EV_CNT_W      = $clog2(MAX_EV + 1);

    localparam logic [THR_W-1:0] THR_LONG_RST  = THR_W'(5000);
    localparam logic [THR_W-1:0] THR_VLONG_RST = THR_W'(10000);

    localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS      = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_VERY_LONG_PRESS = CFG_IDX_W'(1);

    typedef enum logic [1:0] {
        G_NOT   = 2'd0,
        G_SHORT = 2'd1,
        G_LONG  = 2'd2,
        G_VLONG = 2'd3
    } grade_t;

    localparam logic [1:0] EAR_SMALL = 2'd0;
    localparam logic [1:0] EAR_BIG   = 2'd1;
    localparam logic [1:0] EAR_BOTH  = 2'd2;

    localparam logic KIND_PRESS   = 1'b0;
    localparam logic KIND_RELEASE = 1'b1;

    localparam logic [1:0] ORIENT_FRONT = 2'd1;
    localparam logic [1:0] ORIENT_DOWN  = 2'd2;

    localparam logic [2:0] CMD_NONE     = 3'd0;
    localparam logic [2:0] CMD_VOL_DOWN = 3'd1;
    localparam logic [2:0] CMD_VOL_UP   = 3'd2;
    localparam logic [2:0] CMD_SLEEP    = 3'd3;
    localparam logic [2:0] CMD_RESTART  = 3'd4;

    typedef struct packed {
        logic [1:0] ear;
        logic       kind;
        grade_t     length;
        logic [2:0] command;
    } evt_t;

    typedef struct packed {
        evt_t [MAX_EV-1:0]     evts;
        logic [EV_CNT_W-1:0]   cnt;
    } evt_group_t;

    function automatic logic [2:0] cmd_of(logic [1:0] ear, logic kind, grade_t len,
                                          logic [1:0] orient);
        logic [2:0] cmd;
        cmd = CMD_NONE;
        if (kind == KIND_PRESS)
        begin
            if (len == G_SHORT)
            begin
                if (ear == EAR_SMALL)
                    cmd = CMD_VOL_DOWN;
                else if (ear == EAR_BIG)
                    cmd = CMD_VOL_UP;
            end
            else if (len == G_VLONG && ear == EAR_BOTH)
            begin
                if (orient == ORIENT_FRONT)
                    cmd = CMD_SLEEP;
                else if (orient == ORIENT_DOWN)
                    cmd = CMD_RESTART;
            end
        end
        return cmd;
    endfunction

    function automatic evt_t make_evt(logic [1:0] ear, logic kind, grade_t len,
                                      logic [1:0] orient);
        evt_t e;
        e.ear     = ear;
        e.kind    = kind;
        e.length  = len;
        e.command = cmd_of(ear, kind, len, orient);
        return e;
    endfunction

endpackage

// File: rtl/tbpdc_if.sv
`timescale 1ns / 1ps

interface tbpdc_tick_if;
    logic       valid;
    logic       ready;
    logic       small_pressed;
    logic       big_pressed;
    logic [1:0] orientation;

    modport source (output valid, small_pressed, big_pressed, orientation, input ready);
    modport sink   (input valid, small_pressed, big_pressed, orientation, output ready);
endinterface

interface tbpdc_evt_if;
    logic       valid;
    logic       ready;
    logic [1:0] ear;
    logic       kind;
    logic [1:0] length;
    logic [2:0] command;
    logic       last;

    modport source (output valid, ear, kind, length, command, last, input ready);
    modport sink   (input valid, ear, kind, length, command, last, output ready);
endinterface

interface tbpdc_cfg_if;
    import tbpdc_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [THR_W-1:0]     data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/two_button_press_duration_classifier.sv
`timescale 1ns / 1ps

// Press duration classifier for a small and a big button with joint press detection.
// One tick item is taken per clock while the two-deep event queue has room, so a steady
// stream of ticks runs at one item per cycle as long as each tick raises at most one
// event and the sink keeps up; each event leaves on its own cycle while the sink is ready,
// so a tick with several events holds the port until all have left. The last event of a
// tick has last set; ticks without events produce nothing. Both thresholds are written
// through the configuration channel (index 0 long press, index 1 very long press,
// other indexes ignored) and should only change while no events are pending.

module two_button_press_duration_classifier #(
    parameter int TIME_BITS = tbpdc_pkg::TIME_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    tbpdc_tick_if.sink  tick,
    tbpdc_evt_if.source evt,
    tbpdc_cfg_if.sink   cfg
);
    import tbpdc_pkg::*;

    localparam int CMP_W = (TIME_BITS > THR_W) ? TIME_BITS : THR_W;
    localparam logic [TIME_BITS-1:0] HELD_MAX = {TIME_BITS{1'b1}};

    logic [THR_W-1:0]     long_reg, long_next;
    logic [THR_W-1:0]     vlong_reg, vlong_next;
    logic                 s_level_reg, b_level_reg;
    logic [TIME_BITS-1:0] s_held_reg, s_held_next;
    logic [TIME_BITS-1:0] b_held_reg, b_held_next;
    grade_t               s_grade_reg, s_grade_next;
    grade_t               b_grade_reg, b_grade_next;
    grade_t               both_grade_reg, both_grade_next;

    evt_group_t           grp_reg [2];
    logic                 wr_ptr_reg, rd_ptr_reg;
    logic [1:0]           gcnt_reg, gcnt_next;
    logic [EV_IDX_W-1:0]  idx_reg, idx_next;

    logic       accept, push, pop, head_last;
    logic       s_rel, b_rel, s_prom, b_prom;
    grade_t     s_grade_p, b_grade_p, both_p;
    evt_t       cand [MAX_EV];
    logic       cand_v [MAX_EV];
    evt_group_t grp_new;
    evt_group_t head;

    function automatic grade_t promote(logic lvl, logic ge_l, logic ge_vl, grade_t g);
        grade_t r;
        r = g;
        if (lvl && ge_vl && g == G_LONG)
            r = G_VLONG;
        else if (lvl && ge_l && g == G_SHORT)
            r = G_LONG;
        else if (lvl && g == G_NOT)
            r = G_SHORT;
        return r;
    endfunction

    // configuration
    assign cfg.ready = 1'b1;

    always_comb
    begin
        long_next  = long_reg;
        vlong_next = vlong_reg;
        if (cfg.valid)
        begin
            case (cfg.index)
                REG_LONG_PRESS:      long_next  = cfg.data;
                REG_VERY_LONG_PRESS: vlong_next = cfg.data;
                default: ;
            endcase
        end
    end

    // tick evaluation
    assign tick.ready = (gcnt_reg != 2'd2);
    assign accept     = tick.valid && tick.ready;

    always_comb
    begin
        logic s_chg, b_chg;
        s_chg       = tick.small_pressed != s_level_reg;
        b_chg       = tick.big_pressed != b_level_reg;
        s_rel       = s_chg && !tick.small_pressed;
        b_rel       = b_chg && !tick.big_pressed;
        s_held_next = s_chg ? '0 : ((s_held_reg == HELD_MAX) ? s_held_reg
                                                             : s_held_reg + 1'b1);
        b_held_next = b_chg ? '0 : ((b_held_reg == HELD_MAX) ? b_held_reg
                                                             : b_held_reg + 1'b1);
        s_grade_p = promote(tick.small_pressed,
                            CMP_W'(s_held_next) >= CMP_W'(long_reg),
                            CMP_W'(s_held_next) >= CMP_W'(vlong_reg), s_grade_reg);
        b_grade_p = promote(tick.big_pressed,
                            CMP_W'(b_held_next) >= CMP_W'(long_reg),
                            CMP_W'(b_held_next) >= CMP_W'(vlong_reg), b_grade_reg);
        s_prom = s_grade_p != s_grade_reg;
        b_prom = b_grade_p != b_grade_reg;

        cand_v[0] = s_prom && !b_level_reg && b_grade_reg == G_NOT;
        cand[0]   = make_evt(EAR_SMALL, KIND_PRESS, s_grade_p, tick.orientation);
        cand_v[1] = b_prom && !tick.small_pressed && s_grade_p == G_NOT;
        cand[1]   = make_evt(EAR_BIG, KIND_PRESS, b_grade_p, tick.orientation);

        both_p = both_grade_reg;
        if (s_grade_p == G_VLONG && b_grade_p == G_VLONG && both_grade_reg == G_LONG)
            both_p = G_VLONG;
        else if (s_grade_p == G_LONG && b_grade_p == G_LONG && both_grade_reg == G_SHORT)
            both_p = G_LONG;
        else if (s_grade_p == G_SHORT && b_grade_p == G_SHORT && both_grade_reg == G_NOT)
            both_p = G_SHORT;
        cand_v[2] = both_p != both_grade_reg;
        cand[2]   = make_evt(EAR_BOTH, KIND_PRESS, both_p, tick.orientation);

        s_grade_next    = s_grade_p;
        b_grade_next    = b_grade_p;
        both_grade_next = both_p;
        cand_v[3]       = 1'b0;
        cand[3]         = make_evt(EAR_SMALL, KIND_RELEASE, s_grade_p, tick.orientation);
        if (both_p == G_NOT)
        begin
            if (s_rel)
            begin
                cand_v[3]    = 1'b1;
                s_grade_next = G_NOT;
            end
            else if (b_rel)
            begin
                cand_v[3]    = 1'b1;
                cand[3]      = make_evt(EAR_BIG, KIND_RELEASE, b_grade_p, tick.orientation);
                b_grade_next = G_NOT;
            end
        end
        else if (s_rel || b_rel)
        begin
            cand_v[3]       = 1'b1;
            cand[3]         = make_evt(EAR_BOTH, KIND_RELEASE, both_p, tick.orientation);
            s_grade_next    = G_NOT;
            b_grade_next    = G_NOT;
            both_grade_next = G_NOT;
        end
    end

    // pack the events of this tick in order
    always_comb
    begin
        grp_new = '0;
        for (int i = 0; i < MAX_EV; i++)
        begin
            if (cand_v[i])
            begin
                grp_new.evts[grp_new.cnt[EV_IDX_W-1:0]] = cand[i];
                grp_new.cnt = grp_new.cnt + 1'b1;
            end
        end
    end

    // event queue
    assign head      = grp_reg[rd_ptr_reg];
    assign head_last = ({1'b0, idx_reg} == EV_CNT_W'(head.cnt - 1'b1));
    assign push      = accept && (grp_new.cnt != '0);
    assign pop       = evt.valid && evt.ready && head_last;

    always_comb
    begin
        gcnt_next = gcnt_reg;
        if (push && !pop)
            gcnt_next = gcnt_reg + 1'b1;
        else if (pop && !push)
            gcnt_next = gcnt_reg - 1'b1;
        idx_next = idx_reg;
        if (pop)
            idx_next = '0;
        else if (evt.valid && evt.ready)
            idx_next = idx_reg + 1'b1;
    end

    assign evt.valid   = (gcnt_reg != 2'd0);
    assign evt.ear     = head.evts[idx_reg].ear;
    assign evt.kind    = head.evts[idx_reg].kind;
    assign evt.length  = head.evts[idx_reg].length;
    assign evt.command = head.evts[idx_reg].command;
    assign evt.last    = head_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            long_reg       <= THR_LONG_RST;
            vlong_reg      <= THR_VLONG_RST;
            s_level_reg    <= 1'b0;
            b_level_reg    <= 1'b0;
            s_held_reg     <= '0;
            b_held_reg     <= '0;
            s_grade_reg    <= G_NOT;
            b_grade_reg    <= G_NOT;
            both_grade_reg <= G_NOT;
            wr_ptr_reg     <= 1'b0;
            rd_ptr_reg     <= 1'b0;
            gcnt_reg       <= 2'd0;
            idx_reg        <= '0;
        end
        else
        begin
            long_reg  <= long_next;
            vlong_reg <= vlong_next;
            if (accept)
            begin
                s_level_reg    <= tick.small_pressed;
                b_level_reg    <= tick.big_pressed;
                s_held_reg     <= s_held_next;
                b_held_reg     <= b_held_next;
                s_grade_reg    <= s_grade_next;
                b_grade_reg    <= b_grade_next;
                both_grade_reg <= both_grade_next;
            end
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
            gcnt_reg <= gcnt_next;
            idx_reg  <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            grp_reg[wr_ptr_reg] <= grp_new;
    end

endmodule

// File: rtl/tbpdc_checker.sv
`timescale 1ns / 1ps

module tbpdc_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       evt_valid,
    input logic       evt_ready,
    input logic [1:0] evt_ear,
    input logic       evt_kind,
    input logic [1:0] evt_length,
    input logic [2:0] evt_command
);
    import tbpdc_pkg::*;

    a_evt_hold: assert property (@(posedge clk) disable iff (!rst_n)
        evt_valid && !evt_ready |=> evt_valid && $stable(evt_command) && $stable(evt_ear))
        else $error("event dropped or changed while stalled");

    a_cmd_press: assert property (@(posedge clk) disable iff (!rst_n)
        evt_valid && evt_command != CMD_NONE |-> evt_kind == KIND_PRESS)
        else $error("command on a release event");

    a_cmd_volume: assert property (@(posedge clk) disable iff (!rst_n)
        evt_valid && (evt_command == CMD_VOL_DOWN || evt_command == CMD_VOL_UP)
        |-> evt_length == G_SHORT && evt_ear != EAR_BOTH)
        else $error("volume command not from a short single press");

    a_cmd_power: assert property (@(posedge clk) disable iff (!rst_n)
        evt_valid && (evt_command == CMD_SLEEP || evt_command == CMD_RESTART)
        |-> evt_length == G_VLONG && evt_ear == EAR_BOTH)
        else $error("sleep or restart not from a very long joint press");

endmodule

bind two_button_press_duration_classifier tbpdc_checker u_tbpdc_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .evt_valid   (evt.valid),
    .evt_ready   (evt.ready),
    .evt_ear     (evt.ear),
    .evt_kind    (evt.kind),
    .evt_length  (evt.length),
    .evt_command (evt.command)
);

// File: sim/two_button_press_duration_classifier_tb.sv
`timescale 1ns / 1ps

module two_button_press_duration_classifier_tb;
    import tbpdc_pkg::*;

    localparam int HELD_W = TIME_BITS_DEF;
    localparam logic [HELD_W-1:0] HELD_MAX = '1;
    localparam logic [THR_W-1:0] THR_MAX = '1;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LO = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_HI = '1;
    localparam logic [1:0] ORIENT_OTHER = 2'd0;
    localparam logic [1:0] ORIENT_CODE3 = 2'd3;

    typedef struct {
        logic [1:0] ear;
        logic       kind;
        grade_t     length;
        logic [2:0] command;
        logic       last;
    } press_event_t;

    class press_tracker;
        logic [THR_W-1:0]  long_thr;
        logic [THR_W-1:0]  vlong_thr;
        logic              small_lvl;
        logic              big_lvl;
        logic [HELD_W-1:0] small_held;
        logic [HELD_W-1:0] big_held;
        grade_t            small_g;
        grade_t            big_g;
        grade_t            both_g;
        press_event_t      pending_events[$];
        int                mismatches;
        int                ticks_taken;
        int                events_matched;

        function new();
            long_thr       = THR_LONG_RST;
            vlong_thr      = THR_VLONG_RST;
            small_lvl      = 1'b0;
            big_lvl        = 1'b0;
            small_held     = '0;
            big_held       = '0;
            small_g        = G_NOT;
            big_g          = G_NOT;
            both_g         = G_NOT;
            mismatches     = 0;
            ticks_taken    = 0;
            events_matched = 0;
        endfunction

        function void write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [THR_W-1:0] val);
            if (idx == REG_LONG_PRESS)
                long_thr = val;
            else if (idx == REG_VERY_LONG_PRESS)
                vlong_thr = val;
        endfunction

        function void take_level(input logic lvl, inout logic cur,
                                 inout logic [HELD_W-1:0] held, output bit released);
            released = 1'b0;
            if (lvl != cur)
            begin
                released = !lvl;
                cur      = lvl;
                held     = '0;
            end
            else if (held != HELD_MAX)
                held = held + 1'b1;
        endfunction

        function bit promote(input logic lvl, input logic [HELD_W-1:0] held, inout grade_t g);
            if (lvl && held >= vlong_thr && g == G_LONG)
                g = G_VLONG;
            else if (lvl && held >= long_thr && g == G_SHORT)
                g = G_LONG;
            else if (lvl && g == G_NOT)
                g = G_SHORT;
            else
                return 1'b0;
            return 1'b1;
        endfunction

        function press_event_t event_of(input logic [1:0] ear, input logic kind,
                                        input grade_t len, input logic [1:0] orient);
            press_event_t e;
            e.ear     = ear;
            e.kind    = kind;
            e.length  = len;
            e.last    = 1'b0;
            e.command = CMD_NONE;
            if (kind == KIND_PRESS)
            begin
                if (len == G_SHORT && ear == EAR_SMALL)
                    e.command = CMD_VOL_DOWN;
                else if (len == G_SHORT && ear == EAR_BIG)
                    e.command = CMD_VOL_UP;
                else if (len == G_VLONG && ear == EAR_BOTH && orient == ORIENT_FRONT)
                    e.command = CMD_SLEEP;
                else if (len == G_VLONG && ear == EAR_BOTH && orient == ORIENT_DOWN)
                    e.command = CMD_RESTART;
            end
            return e;
        endfunction

        function void take_tick(input logic s, input logic b, input logic [1:0] o);
            press_event_t tick_events[$];
            bit           small_rel;
            bit           big_rel;
            bit           chord_up;
            ticks_taken++;

            take_level(s, small_lvl, small_held, small_rel);
            if (promote(small_lvl, small_held, small_g) && !big_lvl && big_g == G_NOT)
                tick_events.push_back(event_of(EAR_SMALL, KIND_PRESS, small_g, o));

            take_level(b, big_lvl, big_held, big_rel);
            if (promote(big_lvl, big_held, big_g) && !small_lvl && small_g == G_NOT)
                tick_events.push_back(event_of(EAR_BIG, KIND_PRESS, big_g, o));

            chord_up = 1'b1;
            if (small_g == G_VLONG && big_g == G_VLONG && both_g == G_LONG)
                both_g = G_VLONG;
            else if (small_g == G_LONG && big_g == G_LONG && both_g == G_SHORT)
                both_g = G_LONG;
            else if (small_g == G_SHORT && big_g == G_SHORT && both_g == G_NOT)
                both_g = G_SHORT;
            else
                chord_up = 1'b0;
            if (chord_up)
                tick_events.push_back(event_of(EAR_BOTH, KIND_PRESS, both_g, o));

            // a single release is reported per tick unless a joint press is open
            if (both_g == G_NOT)
            begin
                if (small_rel)
                begin
                    tick_events.push_back(event_of(EAR_SMALL, KIND_RELEASE, small_g, o));
                    small_g = G_NOT;
                end
                else if (big_rel)
                begin
                    tick_events.push_back(event_of(EAR_BIG, KIND_RELEASE, big_g, o));
                    big_g = G_NOT;
                end
            end
            else if (small_rel || big_rel)
            begin
                tick_events.push_back(event_of(EAR_BOTH, KIND_RELEASE, both_g, o));
                both_g  = G_NOT;
                small_g = G_NOT;
                big_g   = G_NOT;
            end

            if (tick_events.size() > 0)
                tick_events[tick_events.size()-1].last = 1'b1;
            foreach (tick_events[i])
                pending_events.push_back(tick_events[i]);
        endfunction

        function void match_event(input logic [1:0] ear, input logic kind,
                                  input logic [1:0] length, input logic [2:0] command,
                                  input logic last);
            press_event_t want;
            if (pending_events.size() == 0)
            begin
                $error("unexpected item: ear %0d kind %0d length %0d command %0d last %0d",
                       ear, kind, length, command, last);
                mismatches++;
                return;
            end
            want = pending_events.pop_front();
            events_matched++;
            if (ear !== want.ear)
            begin
                $error("ear: expected %0d, got %0d", want.ear, ear);
                mismatches++;
            end
            if (kind !== want.kind)
            begin
                $error("kind: expected %0d, got %0d", want.kind, kind);
                mismatches++;
            end
            if (length !== want.length)
            begin
                $error("length: expected %0d, got %0d", want.length, length);
                mismatches++;
            end
            if (command !== want.command)
            begin
                $error("command: expected %0d, got %0d", want.command, command);
                mismatches++;
            end
            if (last !== want.last)
            begin
                $error("last: expected %0d, got %0d", want.last, last);
                mismatches++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    int   src_idle_pct    = 0;
    int   snk_stall_pct   = 0;
    int   hold_off_cycles = 0;
    int   settings_used   = 1;

    press_tracker tracker = new();

    tbpdc_tick_if tick ();
    tbpdc_evt_if  evt ();
    tbpdc_cfg_if  cfg ();

    two_button_press_duration_classifier dut (
        .clk   (clk),
        .rst_n (rst_n),
        .tick  (tick.sink),
        .evt   (evt.source),
        .cfg   (cfg.sink)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("== FAIL ==");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (tick.valid && tick.ready)
                tracker.take_tick(tick.small_pressed, tick.big_pressed, tick.orientation);
            if (evt.valid && evt.ready)
                tracker.match_event(evt.ear, evt.kind, evt.length, evt.command, evt.last);
            if (cfg.valid && cfg.ready)
                tracker.write_reg(cfg.index, cfg.data);
        end
    end

    // event side: random stalls, or a long hold-off when one is asked for
    initial
    begin
        evt.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off_cycles > 0)
            begin
                evt.ready <= 1'b0;
                hold_off_cycles = hold_off_cycles - 1;
            end
            else
                evt.ready <= ($urandom_range(99) >= snk_stall_pct);
        end
    end

    task automatic send_tick(input logic s, input logic b, input logic [1:0] o);
        while ($urandom_range(99) < src_idle_pct)
        begin
            tick.valid <= 1'b0;
            @(posedge clk);
        end
        tick.valid         <= 1'b1;
        tick.small_pressed <= s;
        tick.big_pressed   <= b;
        tick.orientation   <= o;
        do
            @(posedge clk);
        while (!tick.ready);
    endtask

    task automatic hold_ticks(input logic s, input logic b, input logic [1:0] o, input int n);
        repeat (n)
            send_tick(s, b, o);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [THR_W-1:0] val);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= val;
        do
            @(posedge clk);
        while (!cfg.ready);
        cfg.valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic drain_events();
        tick.valid <= 1'b0;
        @(posedge clk);
        while (tracker.pending_events.size() != 0)
            @(posedge clk);
        repeat (12) @(posedge clk);
    endtask

    task automatic set_thresholds(input logic [THR_W-1:0] long_ms,
                                  input logic [THR_W-1:0] vlong_ms);
        cfg_write(REG_LONG_PRESS, long_ms);
        cfg_write(REG_VERY_LONG_PRESS, vlong_ms);
        settings_used++;
    endtask

    // mostly held levels of random length that may cross low thresholds, some flicker
    task automatic random_ticks(input int n);
        int   sent;
        int   span;
        int   cap;
        logic s;
        logic b;
        sent = 0;
        while (sent < n)
        begin
            if ($urandom_range(99) < 80)
            begin
                s   = 1'($urandom_range(1));
                b   = 1'($urandom_range(1));
                cap = int'(tracker.long_thr);
                if (int'(tracker.vlong_thr) > cap)
                    cap = int'(tracker.vlong_thr);
                cap = cap + 3;
                if (cap > 24)
                    cap = 24;
                span = $urandom_range(cap, 1);
                repeat (span)
                    send_tick(s, b, 2'($urandom_range(3)));
            end
            else
            begin
                span = $urandom_range(4, 1);
                repeat (span)
                    send_tick(1'($urandom_range(1)), 1'($urandom_range(1)),
                              2'($urandom_range(3)));
            end
            sent += span;
        end
    endtask

    task automatic random_phase(input logic [THR_W-1:0] long_ms, input logic [THR_W-1:0] vlong_ms,
                                input int src_pct, input int snk_pct, input int n);
        set_thresholds(long_ms, vlong_ms);
        src_idle_pct  = src_pct;
        snk_stall_pct = snk_pct;
        random_ticks(n);
        drain_events();
    endtask

    initial
    begin
        rst_n              <= 1'b0;
        tick.valid         <= 1'b0;
        tick.small_pressed <= 1'b0;
        tick.big_pressed   <= 1'b0;
        tick.orientation   <= ORIENT_OTHER;
        cfg.valid          <= 1'b0;
        cfg.index          <= REG_LONG_PRESS;
        cfg.data           <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset thresholds: short joint press, released together
        hold_ticks(1'b1, 1'b1, ORIENT_FRONT, 4);
        hold_ticks(1'b0, 1'b0, ORIENT_OTHER, 2);
        drain_events();

        // thresholds at the counter limit, a short hold stays short
        set_thresholds(THR_MAX, THR_MAX);
        hold_ticks(1'b1, 1'b0, ORIENT_OTHER, 6);
        hold_ticks(1'b0, 1'b0, ORIENT_OTHER, 1);
        drain_events();

        set_thresholds(2, 4);
        cfg_write(REG_UNUSED_LO, THR_MAX);
        cfg_write(REG_UNUSED_HI, '0);
        hold_ticks(1'b1, 1'b0, ORIENT_OTHER, 1);
        hold_ticks(1'b0, 1'b0, ORIENT_OTHER, 1);
        hold_ticks(1'b0, 1'b1, ORIENT_OTHER, 1);
        hold_ticks(1'b0, 1'b0, ORIENT_OTHER, 1);
        hold_ticks(1'b1, 1'b0, ORIENT_FRONT, 5);
        hold_ticks(1'b0, 1'b0, ORIENT_FRONT, 1);
        hold_ticks(1'b1, 1'b1, ORIENT_DOWN, 5);
        hold_ticks(1'b0, 1'b0, ORIENT_DOWN, 1);
        hold_ticks(1'b1, 1'b1, ORIENT_CODE3, 5);
        hold_ticks(1'b0, 1'b1, ORIENT_CODE3, 1);
        hold_ticks(1'b0, 1'b0, ORIENT_CODE3, 1);
        // both let go in one tick with no joint press open
        hold_ticks(1'b1, 1'b0, ORIENT_OTHER, 3);
        hold_ticks(1'b1, 1'b1, ORIENT_OTHER, 1);
        hold_ticks(1'b0, 1'b0, ORIENT_OTHER, 1);
        hold_ticks(1'b0, 1'b1, ORIENT_OTHER, 2);
        hold_ticks(1'b0, 1'b0, ORIENT_OTHER, 1);
        drain_events();

        random_phase(3, 6, 0, 0, 80);
        random_phase(1, 2, 69, 0, 70);
        random_phase(7, 3, 0, 69, 70);
        random_phase(0, 0, 23, 23, 70);

        // receiver holds off while ticks keep coming
        set_thresholds(1, 2);
        src_idle_pct    = 0;
        snk_stall_pct   = 0;
        hold_off_cycles = 150;
        random_ticks(80);
        drain_events();

        repeat (20) @(posedge clk);
        $display("%0d ticks sent, %0d events checked", tracker.ticks_taken,
                 tracker.events_matched);
        $display("%0d threshold settings incl. reset, zero and counter limit, stalls and hold-off",
                 settings_used);
        if (tracker.mismatches == 0 && tracker.pending_events.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
